[rtl/grid_neighbor_index_enumerator_assert.svh]
// Assertion macros used by the neighbor enumerator back end.
`ifndef GRID_NEIGHBOR_INDEX_ENUMERATOR_ASSERT_SVH
`define GRID_NEIGHBOR_INDEX_ENUMERATOR_ASSERT_SVH

`ifndef SYNTHESIS
`define GNIE_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("%m: same-cycle implication failed");
`define GNIE_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("%m: next-cycle implication failed");
`else
`define GNIE_ASSERT_IMPL(label, clk, rst, ante, cons)
`define GNIE_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

[rtl/gnie_pkg.sv]
// Types, constants and offset tables of the grid neighbor index enumerator.
package gnie_pkg;

   localparam int CELL_W        = 30;
   localparam int COORD_W       = 10;
   localparam int COORD_EXT_W   = COORD_W + 1;
   localparam int CSR_DATA_W    = 11;
   localparam int CSR_INDEX_W   = 2;
   localparam int NUM_OFFSETS   = 26;
   localparam int NUM_2D_OFFSETS = 8;
   localparam int OFFSET_IDX_W  = $clog2(NUM_OFFSETS);
   localparam int QUEUE_DEPTH   = 2;
   localparam int QUEUE_PTR_W   = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_W   = $clog2(QUEUE_DEPTH + 1);

   // register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_DIMENSION_COUNT = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_AXIS_SIZE_X     = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_AXIS_SIZE_Y     = 2'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_AXIS_SIZE_Z     = 2'd3;

   // dimension count codes
   localparam logic [1:0] DIM_2D = 2'd2;
   localparam logic [1:0] DIM_3D = 2'd3;

   // per-axis step codes: two's complement -1, 0, +1
   localparam logic [1:0] OFF_NEG  = 2'b11;
   localparam logic [1:0] OFF_ZERO = 2'b00;
   localparam logic [1:0] OFF_POS  = 2'b01;

   typedef struct packed {
      logic [1:0] dx;
      logic [1:0] dy;
      logic [1:0] dz;
   } gnie_offset_type;

   typedef struct packed {
      logic [CELL_W-1:0]      cell_index;
      logic [NUM_OFFSETS-1:0] mask;
      logic                   mode3;
   } gnie_work_type;

   localparam gnie_offset_type OFFSET_3D [NUM_OFFSETS] = '{
      '{OFF_NEG,  OFF_ZERO, OFF_ZERO}, '{OFF_POS,  OFF_ZERO, OFF_ZERO},
      '{OFF_ZERO, OFF_NEG,  OFF_ZERO}, '{OFF_ZERO, OFF_POS,  OFF_ZERO},
      '{OFF_NEG,  OFF_NEG,  OFF_ZERO}, '{OFF_NEG,  OFF_POS,  OFF_ZERO},
      '{OFF_POS,  OFF_NEG,  OFF_ZERO}, '{OFF_POS,  OFF_POS,  OFF_ZERO},
      '{OFF_NEG,  OFF_ZERO, OFF_NEG},  '{OFF_POS,  OFF_ZERO, OFF_NEG},
      '{OFF_ZERO, OFF_NEG,  OFF_NEG},  '{OFF_ZERO, OFF_POS,  OFF_NEG},
      '{OFF_NEG,  OFF_NEG,  OFF_NEG},  '{OFF_NEG,  OFF_POS,  OFF_NEG},
      '{OFF_POS,  OFF_NEG,  OFF_NEG},  '{OFF_POS,  OFF_POS,  OFF_NEG},
      '{OFF_NEG,  OFF_ZERO, OFF_POS},  '{OFF_POS,  OFF_ZERO, OFF_POS},
      '{OFF_ZERO, OFF_NEG,  OFF_POS},  '{OFF_ZERO, OFF_POS,  OFF_POS},
      '{OFF_NEG,  OFF_NEG,  OFF_POS},  '{OFF_NEG,  OFF_POS,  OFF_POS},
      '{OFF_POS,  OFF_NEG,  OFF_POS},  '{OFF_POS,  OFF_POS,  OFF_POS},
      '{OFF_ZERO, OFF_ZERO, OFF_NEG},  '{OFF_ZERO, OFF_ZERO, OFF_POS}
   };

   // planar order: right, left, up row (center, left, right), down row (same)
   localparam gnie_offset_type OFFSET_2D [NUM_2D_OFFSETS] = '{
      '{OFF_POS,  OFF_ZERO, OFF_ZERO}, '{OFF_NEG,  OFF_ZERO, OFF_ZERO},
      '{OFF_ZERO, OFF_POS,  OFF_ZERO}, '{OFF_NEG,  OFF_POS,  OFF_ZERO},
      '{OFF_POS,  OFF_POS,  OFF_ZERO}, '{OFF_ZERO, OFF_NEG,  OFF_ZERO},
      '{OFF_NEG,  OFF_NEG,  OFF_ZERO}, '{OFF_POS,  OFF_NEG,  OFF_ZERO}
   };

   // map a step code to its slot in a {plus, center, minus} flag vector
   function automatic logic [1:0] offset_slot(input logic [1:0] step);
      return step + 2'd1;
   endfunction

endpackage

[rtl/gnie_front.sv]
// Front end: accepts cells and classifies which neighbors lie in bounds.
module gnie_front
   import gnie_pkg::*;
#(
   parameter int SIZE_W = 11
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic [CELL_W-1:0]   req_cell_index,
   input  logic [COORD_W-1:0]  req_coord_x,
   input  logic [COORD_W-1:0]  req_coord_y,
   input  logic [COORD_W-1:0]  req_coord_z,
   input  logic [1:0]          dim_count,
   input  logic [SIZE_W-1:0]   size_x,
   input  logic [SIZE_W-1:0]   size_y,
   input  logic [SIZE_W-1:0]   size_z,
   output logic                push_valid,
   output gnie_work_type       push_entry,
   input  logic                push_ready
);

   logic [COORD_EXT_W-1:0] x_e, y_e, z_e, sx_e, sy_e, sz_e;
   logic [2:0]             ok3_x, ok3_y, ok3_z, ok2_x, ok2_y;
   logic [NUM_OFFSETS-1:0] mask;
   logic                   req_fire, push_fire;
   logic                   stage_valid_ff, stage_valid_in;
   gnie_work_type          stage_entry_ff, stage_entry_in;

   always_comb begin
      x_e  = COORD_EXT_W'(req_coord_x);
      y_e  = COORD_EXT_W'(req_coord_y);
      z_e  = COORD_EXT_W'(req_coord_z);
      sx_e = COORD_EXT_W'(size_x);
      sy_e = COORD_EXT_W'(size_y);
      sz_e = COORD_EXT_W'(size_z);

      // {plus, center, minus} in-bounds flags per axis
      ok3_x = {(x_e + 1'b1) < sx_e, x_e < sx_e, (x_e != '0) && ((x_e - 1'b1) < sx_e)};
      ok3_y = {(y_e + 1'b1) < sy_e, y_e < sy_e, (y_e != '0) && ((y_e - 1'b1) < sy_e)};
      ok3_z = {(z_e + 1'b1) < sz_e, z_e < sz_e, (z_e != '0) && ((z_e - 1'b1) < sz_e)};
      // planar mode tests only the moving side of each axis
      ok2_x = {(x_e + 1'b1) < sx_e, 1'b1, x_e != '0};
      ok2_y = {(y_e + 1'b1) < sy_e, 1'b1, y_e != '0};
   end

   always_comb begin
      mask = '0;
      unique case (dim_count)
         DIM_2D: begin
            for (int i = 0; i < NUM_2D_OFFSETS; i++) begin
               mask[i] = ok2_x[offset_slot(OFFSET_2D[i].dx)] &
                         ok2_y[offset_slot(OFFSET_2D[i].dy)];
            end
         end
         DIM_3D: begin
            for (int i = 0; i < NUM_OFFSETS; i++) begin
               mask[i] = ok3_x[offset_slot(OFFSET_3D[i].dx)] &
                         ok3_y[offset_slot(OFFSET_3D[i].dy)] &
                         ok3_z[offset_slot(OFFSET_3D[i].dz)];
            end
         end
         default: mask = '0;
      endcase
   end

   assign req_ready  = !stage_valid_ff || push_ready;
   assign req_fire   = req_valid && req_ready;
   assign push_valid = stage_valid_ff;
   assign push_fire  = stage_valid_ff && push_ready;
   assign push_entry = stage_entry_ff;

   always_comb begin
      stage_valid_in = stage_valid_ff;
      stage_entry_in = stage_entry_ff;
      if (push_fire) begin
         stage_valid_in = 1'b0;
      end
      if (req_fire) begin
         // drop cells with no neighbor in bounds
         stage_valid_in            = (mask != '0);
         stage_entry_in.cell_index = req_cell_index;
         stage_entry_in.mask       = mask;
         stage_entry_in.mode3      = (dim_count == DIM_3D);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= 1'b0;
      end else begin
         stage_valid_ff <= stage_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      stage_entry_ff <= stage_entry_in;
   end

endmodule

[rtl/gnie_queue.sv]
// Short work queue between the classifying front end and the emitting back end.
module gnie_queue
   import gnie_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          push_valid,
   output logic          push_ready,
   input  gnie_work_type push_entry,
   output logic          pop_valid,
   input  logic          pop_ready,
   output gnie_work_type pop_entry
);

   gnie_work_type          slot_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_CNT_W-1:0] count_ff, count_in;
   logic                   push_fire, pop_fire;

   assign push_ready = (count_ff != QUEUE_CNT_W'(QUEUE_DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_entry  = slot_ff[rd_ptr_ff];
   assign push_fire  = push_valid && push_ready;
   assign pop_fire   = pop_valid && pop_ready;

   // depth is a power of two, so the pointers wrap on their own
   always_comb begin
      wr_ptr_in = push_fire ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop_fire ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push_fire && !pop_fire) begin
         count_in = count_ff + 1'b1;
      end else if (pop_fire && !push_fire) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_fire) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

[rtl/gnie_back.sv]
// Back end: walks a cell's neighbor mask and emits one neighbor index per beat.
`include "grid_neighbor_index_enumerator_assert.svh"

module gnie_back
   import gnie_pkg::*;
#(
   parameter int SIZE_W = 11
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                pop_valid,
   output logic                pop_ready,
   input  gnie_work_type       pop_entry,
   input  logic [SIZE_W-1:0]   stride_x,
   input  logic [2*SIZE_W-1:0] stride_xy,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic [CELL_W-1:0]   rsp_neighbor_index,
   output logic                rsp_last_neighbor
);

   logic                    cur_valid_ff, cur_valid_in;
   gnie_work_type           cur_entry_ff, cur_entry_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [CELL_W-1:0]       rsp_index_ff, rsp_index_in;
   logic                    rsp_last_ff, rsp_last_in;
   logic [OFFSET_IDX_W-1:0] pick;
   logic [NUM_OFFSETS-1:0]  mask_rest;
   gnie_offset_type         step;
   logic [CELL_W-1:0]       sx_w, sxy_w, term_x, term_y, term_z;
   logic                    advance, emit_last, pop_fire;

   // lowest set bit of the remaining mask
   always_comb begin
      pick = '0;
      for (int i = NUM_OFFSETS - 1; i >= 0; i--) begin
         if (cur_entry_ff.mask[i]) begin
            pick = OFFSET_IDX_W'(i);
         end
      end
   end

   assign mask_rest = cur_entry_ff.mask & (cur_entry_ff.mask - 1'b1);
   assign emit_last = (mask_rest == '0);
   assign advance   = cur_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign pop_ready = !cur_valid_ff || (advance && emit_last);
   assign pop_fire  = pop_valid && pop_ready;

   always_comb begin
      step  = cur_entry_ff.mode3 ? OFFSET_3D[pick] : OFFSET_2D[pick[2:0]];
      sx_w  = CELL_W'(stride_x);
      sxy_w = CELL_W'(stride_xy);
      unique case (step.dx)
         OFF_POS: term_x = CELL_W'(1);
         OFF_NEG: term_x = '1;
         default: term_x = '0;
      endcase
      unique case (step.dy)
         OFF_POS: term_y = sx_w;
         OFF_NEG: term_y = '0 - sx_w;
         default: term_y = '0;
      endcase
      unique case (step.dz)
         OFF_POS: term_z = sxy_w;
         OFF_NEG: term_z = '0 - sxy_w;
         default: term_z = '0;
      endcase
   end

   always_comb begin
      cur_valid_in = cur_valid_ff;
      cur_entry_in = cur_entry_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_index_in = rsp_index_ff;
      rsp_last_in  = rsp_last_ff;
      if (advance) begin
         rsp_valid_in      = 1'b1;
         rsp_index_in      = cur_entry_ff.cell_index + term_x + term_y + term_z;
         rsp_last_in       = emit_last;
         cur_entry_in.mask = mask_rest;
         if (emit_last) begin
            cur_valid_in = 1'b0;
         end
      end
      if (pop_fire) begin
         cur_valid_in = 1'b1;
         cur_entry_in = pop_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         cur_valid_ff <= cur_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_entry_ff <= cur_entry_in;
      rsp_index_ff <= rsp_index_in;
      rsp_last_ff  <= rsp_last_in;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_neighbor_index = rsp_index_ff;
   assign rsp_last_neighbor  = rsp_last_ff;

   `GNIE_ASSERT_IMPL(a_no_empty_work, clock, reset, cur_valid_ff, cur_entry_ff.mask != '0)
   `GNIE_ASSERT_NEXT(a_keep_walking, clock, reset, advance && !emit_last, cur_valid_ff)
   `GNIE_ASSERT_NEXT(a_drain_idle, clock, reset, advance && emit_last && !pop_valid, !cur_valid_ff)
   `GNIE_ASSERT_NEXT(a_emit_lands, clock, reset, advance, rsp_valid_ff && (rsp_last_ff == $past(emit_last)))

endmodule

[rtl/grid_neighbor_index_enumerator.sv]
// Top level of the grid neighbor index enumerator: config registers and the front/queue/back chain.
// A request is registered in the front stage, the queue, the walker and then the output register.
// Throughput: one neighbor beat per cycle from the mask walker unless rsp_ready stalls it; up
//   to 8 in-bounds neighbors per cell planar, up to 26 volumetric; a cell with none costs only
//   its request beat. The front end takes requests while the walker runs, until the queue fills.
// Reset: synchronous; clears all valid flags and queue pointers and sets 2-D, 1x1x1 grid.
module grid_neighbor_index_enumerator
   import gnie_pkg::*;
#(
   parameter int MAX_AXIS_CELLS = 1024
) (
   input  logic                   clock,
   input  logic                   reset,
   // request channel
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic [CELL_W-1:0]      req_cell_index,
   input  logic [COORD_W-1:0]     req_coord_x,
   input  logic [COORD_W-1:0]     req_coord_y,
   input  logic [COORD_W-1:0]     req_coord_z,
   // response channel
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic [CELL_W-1:0]      rsp_neighbor_index,
   output logic                   rsp_last_neighbor,
   // register write port
   input  logic                   csr_write_enable,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_write_data
);

   // Axis sizes are stored only as wide as the largest allowed size needs,
   // capped at the register width.
   localparam int SIZE_W = ($clog2(MAX_AXIS_CELLS + 1) < CSR_DATA_W) ?
                           $clog2(MAX_AXIS_CELLS + 1) : CSR_DATA_W;

   logic [1:0]          dim_ff;
   logic [SIZE_W-1:0]   size_x_ff, size_y_ff, size_z_ff;
   logic [SIZE_W-1:0]   size_sat;
   logic [2*SIZE_W-1:0] stride_xy_ff, stride_xy_in;

   logic                push_valid, push_ready, pop_valid, pop_ready;
   gnie_work_type       push_entry, pop_entry;

   // Clamp a written axis size to the largest supported size.
   assign size_sat = (int'(csr_write_data) > MAX_AXIS_CELLS) ?
                     SIZE_W'(MAX_AXIS_CELLS) : SIZE_W'(csr_write_data);

   always_ff @(posedge clock) begin
      if (reset) begin
         dim_ff    <= DIM_2D;
         size_x_ff <= SIZE_W'(1);
         size_y_ff <= SIZE_W'(1);
         size_z_ff <= SIZE_W'(1);
      end else if (csr_write_enable) begin
         unique case (csr_index)
            CSR_DIMENSION_COUNT: dim_ff    <= csr_write_data[1:0];
            CSR_AXIS_SIZE_X:     size_x_ff <= size_sat;
            CSR_AXIS_SIZE_Y:     size_y_ff <= size_sat;
            CSR_AXIS_SIZE_Z:     size_z_ff <= size_sat;
            default: ;
         endcase
      end
   end

   // Plane stride X*Y, registered in the cycle after the size registers change. Writes must
   // only happen while idle (the user is bound; the block does not enforce it). A new cell
   // passes the front stage and queue before the walker reads the product, which has settled.
   assign stride_xy_in = (2*SIZE_W)'(size_x_ff) * (2*SIZE_W)'(size_y_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         stride_xy_ff <= (2*SIZE_W)'(1);
      end else begin
         stride_xy_ff <= stride_xy_in;
      end
   end

   // Front: take a request beat, work out the in-bounds neighbor mask,
   // drop cells that have none, hold the rest in one stage register.
   gnie_front #(
      .SIZE_W (SIZE_W)
   ) u_front (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_cell_index (req_cell_index),
      .req_coord_x    (req_coord_x),
      .req_coord_y    (req_coord_y),
      .req_coord_z    (req_coord_z),
      .dim_count      (dim_ff),
      .size_x         (size_x_ff),
      .size_y         (size_y_ff),
      .size_z         (size_z_ff),
      .push_valid     (push_valid),
      .push_entry     (push_entry),
      .push_ready     (push_ready)
   );

   // Queue: decouple the front stage from the mask walker so the front can go on taking
   // cells while a long neighbor list drains, until the queue is full.
   gnie_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_entry (push_entry),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_entry  (pop_entry)
   );

   // Back: walk the mask lowest bit first, add the offset's stride terms to
   // the center index (modulo 2^30) and hold each beat in the output register.
   // The next cell is loaded in the same cycle as the previous one's last beat.
   gnie_back #(
      .SIZE_W (SIZE_W)
   ) u_back (
      .clock              (clock),
      .reset              (reset),
      .pop_valid          (pop_valid),
      .pop_ready          (pop_ready),
      .pop_entry          (pop_entry),
      .stride_x           (size_x_ff),
      .stride_xy          (stride_xy_ff),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_neighbor_index (rsp_neighbor_index),
      .rsp_last_neighbor  (rsp_last_neighbor)
   );

endmodule

[sim/grid_neighbor_index_enumerator_tb.sv]
// Self-checking testbench for the grid neighbor index enumerator: directed and random cells.
module grid_neighbor_index_enumerator_tb;
   import gnie_pkg::*;

   // Idle odds per side, in percent, and run-time limits in cycles
   localparam int IDLE_PCT      = 27;
   localparam int DRAIN_PAUSE   = 8;
   localparam int TAIL_PAUSE    = 12;
   localparam int QUIET_LIMIT   = 2000;
   localparam int AXIS_CAP      = 1024;
   localparam int OFFSET_COUNT  = 26;
   localparam int RANDOM_PHASES = 10;
   localparam int PHASE_CELLS   = 40;

   // Dimension codes with no neighborhood at all
   localparam logic [1:0] DIM_NONE = 2'd0;
   localparam logic [1:0] DIM_LINE = 2'd1;

   // Volumetric walk order: three rows of eight x/y steps at z 0, -1 and +1, then the two pure z steps
   localparam int STEP_X [OFFSET_COUNT] = '{
      -1, 1, 0, 0, -1, -1, 1, 1,  -1, 1, 0, 0, -1, -1, 1, 1,
      -1, 1, 0, 0, -1, -1, 1, 1,   0, 0};
   localparam int STEP_Y [OFFSET_COUNT] = '{
      0, 0, -1, 1, -1, 1, -1, 1,   0, 0, -1, 1, -1, 1, -1, 1,
      0, 0, -1, 1, -1, 1, -1, 1,   0, 0};
   localparam int STEP_Z [OFFSET_COUNT] = '{
      0, 0, 0, 0, 0, 0, 0, 0,     -1, -1, -1, -1, -1, -1, -1, -1,
      1, 1, 1, 1, 1, 1, 1, 1,     -1, 1};

   typedef struct packed {
      logic [CELL_W-1:0]  cell_idx;
      logic [COORD_W-1:0] x;
      logic [COORD_W-1:0] y;
      logic [COORD_W-1:0] z;
   } cell_query_type;

   typedef struct packed {
      logic [CELL_W-1:0] index;
      logic              last;
   } neighbor_type;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_ready;
   logic [CELL_W-1:0]      req_cell_index = '0;
   logic [COORD_W-1:0]     req_coord_x = '0;
   logic [COORD_W-1:0]     req_coord_y = '0;
   logic [COORD_W-1:0]     req_coord_z = '0;
   logic                   rsp_valid;
   logic                   rsp_ready = 1'b0;
   logic [CELL_W-1:0]      rsp_neighbor_index;
   logic                   rsp_last_neighbor;
   logic                   csr_write_enable = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0]  csr_write_data = '0;

   // Shadow copy of the register file, as the block should hold it after saturation
   logic [1:0]  dim_mode = DIM_2D;
   int          size_x = 1;
   int          size_y = 1;
   int          size_z = 1;

   cell_query_type cell_backlog [$];      // cells waiting to be driven
   neighbor_type   awaited_neighbors [$]; // predicted neighbor beats, oldest first
   cell_query_type shown;                 // cell currently on the request port
   neighbor_type   want;
   bit          no_gaps = 1'b0;        // suppress idling on both sides
   int          cells_sent = 0;
   int          beats_seen = 0;
   int          fault_count = 0;
   int          settings_applied = 0;
   int          quiet_cycles = 0;

   grid_neighbor_index_enumerator uut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_cell_index     (req_cell_index),
      .req_coord_x        (req_coord_x),
      .req_coord_y        (req_coord_y),
      .req_coord_z        (req_coord_z),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_neighbor_index (rsp_neighbor_index),
      .rsp_last_neighbor  (rsp_last_neighbor),
      .csr_write_enable   (csr_write_enable),
      .csr_index          (csr_index),
      .csr_write_data     (csr_write_data)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // ---------------------------------------------------------------------------------------
   // Neighbor prediction
   // ---------------------------------------------------------------------------------------

   function automatic bit in_span(longint c, longint span);
      return c >= 0 && c < span;
   endfunction

   function automatic int clamp_axis(logic [CSR_DATA_W-1:0] value);
      return (int'(value) > AXIS_CAP) ? AXIS_CAP : int'(value);
   endfunction

   // Append the neighbor beats one accepted cell must produce, in emission order.
   // Planar bounds are checked one-sided, exactly as written: x-1 only against zero,
   // x+1 only against the axis size, so off-grid centers still yield neighbors.
   function automatic void predict_neighbors(cell_query_type q);
      longint       x, y, z, sx, sy, sz, sxy;
      longint       deltas [$];
      neighbor_type beat;
      x   = q.x;
      y   = q.y;
      z   = q.z;
      sx  = size_x;
      sy  = size_y;
      sz  = size_z;
      sxy = sx * sy;
      if (dim_mode == DIM_2D) begin
         if (x + 1 < sx) deltas.insert(deltas.size(), longint'(1));
         if (x - 1 >= 0) deltas.insert(deltas.size(), longint'(-1));
         if (y + 1 < sy) begin
            deltas.insert(deltas.size(), sx);
            if (x - 1 >= 0) deltas.insert(deltas.size(), sx - 1);
            if (x + 1 < sx) deltas.insert(deltas.size(), sx + 1);
         end
         if (y - 1 >= 0) begin
            deltas.insert(deltas.size(), -sx);
            if (x - 1 >= 0) deltas.insert(deltas.size(), -sx - 1);
            if (x + 1 < sx) deltas.insert(deltas.size(), -sx + 1);
         end
      end else if (dim_mode == DIM_3D) begin
         for (int i = 0; i < OFFSET_COUNT; i++) begin
            if (in_span(x + STEP_X[i], sx) && in_span(y + STEP_Y[i], sy) &&
                in_span(z + STEP_Z[i], sz))
               deltas.insert(deltas.size(),
                             STEP_X[i] + STEP_Y[i] * sx + STEP_Z[i] * sxy);
         end
      end
      // other dimension codes produce nothing; indices wrap modulo the field width
      foreach (deltas[k]) begin
         beat.index = CELL_W'(longint'(q.cell_idx) + deltas[k]);
         beat.last  = (k == deltas.size() - 1);
         awaited_neighbors.insert(awaited_neighbors.size(), beat);
      end
   endfunction

   // ---------------------------------------------------------------------------------------
   // Register writes and stimulus helpers
   // ---------------------------------------------------------------------------------------

   task automatic write_reg(logic [CSR_INDEX_W-1:0] idx, logic [CSR_DATA_W-1:0] value);
      @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_index        <= idx;
      csr_write_data   <= value;
      case (idx)
         CSR_DIMENSION_COUNT: dim_mode = value[1:0];
         CSR_AXIS_SIZE_X:     size_x = clamp_axis(value);
         CSR_AXIS_SIZE_Y:     size_y = clamp_axis(value);
         CSR_AXIS_SIZE_Z:     size_z = clamp_axis(value);
         default: ;
      endcase
   endtask

   task automatic apply_setting(logic [1:0] dim, logic [CSR_DATA_W-1:0] ax,
                                logic [CSR_DATA_W-1:0] ay, logic [CSR_DATA_W-1:0] az);
      write_reg(CSR_DIMENSION_COUNT, CSR_DATA_W'(dim));
      write_reg(CSR_AXIS_SIZE_X, ax);
      write_reg(CSR_AXIS_SIZE_Y, ay);
      write_reg(CSR_AXIS_SIZE_Z, az);
      @(posedge clock);
      csr_write_enable <= 1'b0;
      settings_applied++;
   endtask

   // Block until every queued cell went out and every predicted beat came back, then
   // give the block time to finish cells that had nothing to emit.
   task automatic settle();
      do @(negedge clock);
      while (cell_backlog.size() != 0 || req_valid || awaited_neighbors.size() != 0);
      repeat (DRAIN_PAUSE) @(posedge clock);
   endtask

   task automatic queue_cell(int unsigned cell_idx, int unsigned x, int unsigned y,
                             int unsigned z);
      cell_query_type q;
      q.cell_idx = CELL_W'(cell_idx);
      q.x        = COORD_W'(x);
      q.y        = COORD_W'(y);
      q.z        = COORD_W'(z);
      cell_backlog.insert(cell_backlog.size(), q);
   endtask

   // Favor the borders of the axis so that clipped neighborhoods show up often
   function automatic logic [COORD_W-1:0] pick_coord(int span);
      if (span == 0) return COORD_W'($urandom);
      case ($urandom_range(0, 3))
         0:       return '0;
         1:       return COORD_W'(span - 1);
         default: return COORD_W'($urandom_range(0, span - 1));
      endcase
   endfunction

   function automatic logic [CSR_DATA_W-1:0] pick_axis();
      case ($urandom_range(0, 11))
         0:       return '0;
         1:       return CSR_DATA_W'(AXIS_CAP);
         2:       return '1;
         3:       return CSR_DATA_W'($urandom);
         default: return CSR_DATA_W'($urandom_range(1, 6));
      endcase
   endfunction

   // Mostly in-grid cells whose linear index agrees with their coordinates; the rest noise
   function automatic cell_query_type draw_cell();
      cell_query_type q;
      longint         lin;
      if ($urandom_range(0, 99) < 20) begin
         q.cell_idx = CELL_W'($urandom);
         q.x        = COORD_W'($urandom);
         q.y        = COORD_W'($urandom);
         q.z        = COORD_W'($urandom);
         return q;
      end
      q.x = pick_coord(size_x);
      q.y = pick_coord(size_y);
      q.z = pick_coord(size_z);
      lin = longint'(q.x) + longint'(q.y) * size_x;
      if (dim_mode == DIM_3D) lin += longint'(q.z) * size_x * size_y;
      q.cell_idx = CELL_W'(lin);
      return q;
   endfunction

   // ---------------------------------------------------------------------------------------
   // Request driver: predict on each accepted beat, hold while stalled, idle at random
   // ---------------------------------------------------------------------------------------

   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            predict_neighbors(shown);
            cells_sent++;
         end
         if (req_valid && !req_ready) begin
            // hold the beat until the block takes it
         end else if (cell_backlog.size() > 0 &&
                      (no_gaps || $urandom_range(0, 99) >= IDLE_PCT)) begin
            shown = cell_backlog.pop_front();
            req_valid      <= 1'b1;
            req_cell_index <= shown.cell_idx;
            req_coord_x    <= shown.x;
            req_coord_y    <= shown.y;
            req_coord_z    <= shown.z;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // ---------------------------------------------------------------------------------------
   // Response monitor: compare each beat with the oldest prediction, stall at random
   // ---------------------------------------------------------------------------------------

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         beats_seen++;
         if (awaited_neighbors.size() == 0) begin
            fault_count++;
            $display("%0t: unexpected neighbor beat: expected none, actual index %0d last %0b",
                     $time, rsp_neighbor_index, rsp_last_neighbor);
         end else begin
            want = awaited_neighbors.pop_front();
            if (rsp_neighbor_index !== want.index) begin
               fault_count++;
               $display("%0t: neighbor_index: expected %0d, actual %0d",
                        $time, want.index, rsp_neighbor_index);
            end
            if (rsp_last_neighbor !== want.last) begin
               fault_count++;
               $display("%0t: last_neighbor: expected %0b, actual %0b",
                        $time, want.last, rsp_last_neighbor);
            end
         end
      end
      rsp_ready <= no_gaps || ($urandom_range(0, 99) >= IDLE_PCT);
   end

   // Watchdog: end the run if no beat moves on either channel for too long
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("%0t: no beat for %0d cycles, %0d predictions outstanding",
                  $time, QUIET_LIMIT, awaited_neighbors.size());
         $display("grid_neighbor_index_enumerator: mismatch");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // ---------------------------------------------------------------------------------------
   // Test sequence
   // ---------------------------------------------------------------------------------------

   initial begin
      logic [1:0] dim;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Reset grid is 1x1 planar: an in-grid center has no neighbor, off-grid centers
      // still pass the one-sided tests, and one of them wraps below zero
      queue_cell(0, 0, 0, 0);
      queue_cell(0, 1, 0, 0);
      queue_cell(7, 0, 3, 0);

      // Planar 4x3: full center, corners, an edge, wrap above the top index, z ignored
      settle();
      apply_setting(DIM_2D, 4, 3, 1);
      queue_cell(5, 1, 1, 0);
      queue_cell(0, 0, 0, 0);
      queue_cell(11, 3, 2, 0);
      queue_cell(7, 3, 1, 0);
      queue_cell(32'h3FFF_FFFF, 2, 0, 0);
      queue_cell(6, 2, 1, 1023);

      // Volumetric 3x3x3: full 26, corners, a center above the top z plane
      settle();
      apply_setting(DIM_3D, 3, 3, 3);
      queue_cell(13, 1, 1, 1);
      queue_cell(0, 0, 0, 0);
      queue_cell(26, 2, 2, 2);
      queue_cell(40, 1, 1, 3);

      // Largest grid: oversize writes saturate, extreme coordinates and indices
      settle();
      apply_setting(DIM_3D, '1, CSR_DATA_W'(AXIS_CAP), '1);
      queue_cell(32'h3FFF_FFFF, 1023, 1023, 1023);
      queue_cell(0, 0, 0, 0);
      queue_cell(32'h2AAA_5555, 512, 0, 1023);

      // Dimension codes without a neighborhood
      settle();
      apply_setting(DIM_NONE, 3, 3, 3);
      queue_cell(13, 1, 1, 1);
      settle();
      apply_setting(DIM_LINE, 3, 3, 3);
      queue_cell(13, 1, 1, 1);

      // Zero-length axes: nothing in bounds there, but planar y steps still fire
      settle();
      apply_setting(DIM_3D, 3, 0, 3);
      queue_cell(13, 1, 1, 1);
      settle();
      apply_setting(DIM_2D, 0, 4, 1);
      queue_cell(9, 0, 1, 0);

      // Random settings, each followed by a burst of cells; one phase runs gap-free
      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         settle();
         case ($urandom_range(0, 9))
            0:       dim = $urandom_range(0, 1) ? DIM_LINE : DIM_NONE;
            1, 2, 3, 4: dim = DIM_2D;
            default: dim = DIM_3D;
         endcase
         if (phase == 0) dim = DIM_2D;
         if (phase == 1) dim = DIM_3D;
         apply_setting(dim, pick_axis(), pick_axis(), pick_axis());
         no_gaps = (phase == RANDOM_PHASES / 2);
         repeat (PHASE_CELLS) cell_backlog.insert(cell_backlog.size(), draw_cell());
      end

      // Drain, then watch a little longer for stray beats
      do @(negedge clock);
      while (cell_backlog.size() != 0 || req_valid || awaited_neighbors.size() != 0);
      repeat (TAIL_PAUSE) @(posedge clock);

      $display("Sent %0d cells under %0d register settings (planar, volumetric, disabled).",
               cells_sent, settings_applied);
      $display("Checked %0d neighbor beats, %0d faults.", beats_seen, fault_count);
      if (fault_count == 0) begin
         $display("grid_neighbor_index_enumerator: match");
      end else begin
         $display("grid_neighbor_index_enumerator: mismatch");
      end
      $finish;
   end

endmodule

[grid_neighbor_index_enumerator.f]
+incdir+rtl
rtl/gnie_pkg.sv
rtl/gnie_front.sv
rtl/gnie_queue.sv
rtl/gnie_back.sv
rtl/grid_neighbor_index_enumerator.sv
sim/grid_neighbor_index_enumerator_tb.sv
